### design/p2rd_pkg.sv
// ---------------------------------------------------------------------------
// p2rd_pkg: shared definitions for the power-of-two radix digit emitter
// Field widths, radix and status codes, the queue entry and digit helpers.
// ---------------------------------------------------------------------------
package p2rd_pkg;

   localparam int P2RD_WORD_BITS   = 32;
   localparam int P2RD_QUEUE_DEPTH = 2;

   localparam int VALUE_W = 32;
   localparam int RADIX_W = 6;
   localparam int CHAR_W  = 7;
   localparam int SHIFT_W = 3;
   localparam int POS_W   = 5;
   localparam int DIGIT_W = 5;

   localparam logic [RADIX_W-1:0] RADIX_BIN  = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_QUAT = 6'd4;
   localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_B32  = 6'd32;

   localparam logic [SHIFT_W-1:0] SHIFT_NONE = 3'd0;
   localparam logic [SHIFT_W-1:0] SHIFT_BIN  = 3'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_QUAT = 3'd2;
   localparam logic [SHIFT_W-1:0] SHIFT_OCT  = 3'd3;
   localparam logic [SHIFT_W-1:0] SHIFT_HEX  = 3'd4;
   localparam logic [SHIFT_W-1:0] SHIFT_B32  = 3'd5;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_RADIX = 1'b1;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;
   localparam logic [CHAR_W-1:0]  CHAR_ERROR = 7'h00;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 5'd10;

   // One classified transaction waiting for the digit engine.
   typedef struct packed {
      logic [VALUE_W-1:0] value;   // masked word
      logic [SHIFT_W-1:0] shift;   // bits per digit
      logic [POS_W-1:0]   offset;  // bit offset of the top emitted digit
      logic               err;     // invalid radix
   } p2rd_entry_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
      end
      return CHAR_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DIGIT_TEN};
   endfunction

   function automatic logic [DIGIT_W-1:0] digit_mask(input logic [SHIFT_W-1:0] shift);
      case (shift)
         SHIFT_BIN:  return 5'b00001;
         SHIFT_QUAT: return 5'b00011;
         SHIFT_OCT:  return 5'b00111;
         SHIFT_HEX:  return 5'b01111;
         SHIFT_B32:  return 5'b11111;
         default:    return 5'b00000;
      endcase
   endfunction

endpackage

### design/p2rd_if.sv
// ---------------------------------------------------------------------------
// p2rd_if: request and response channels
// Valid/ready channels carrying the word and radix in, digit characters out.
// ---------------------------------------------------------------------------
interface p2rd_req_if;
   import p2rd_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [RADIX_W-1:0] radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);
endinterface

interface p2rd_rsp_if;
   import p2rd_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last;
   logic              status;

   modport source (output valid, output digit_char, output last, output status, input ready);
   modport sink   (input valid, input digit_char, input last, input status, output ready);
endinterface

### design/p2rd_front.sv
// ---------------------------------------------------------------------------
// p2rd_front: request classifier
// Decode the radix, mask the word and locate the top nonzero digit.
// ---------------------------------------------------------------------------
module p2rd_front #(
   parameter int WORD_BITS = p2rd_pkg::P2RD_WORD_BITS
) (
   p2rd_req_if.sink               req_bus,
   input  logic                   push_ready,
   output logic                   push_valid,
   output p2rd_pkg::p2rd_entry_type push_entry
);
   import p2rd_pkg::*;

   localparam int SIG_BITS = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;
   localparam logic [VALUE_W-1:0] WORD_MASK = {VALUE_W{1'b1}} >> (VALUE_W - SIG_BITS);

   logic [VALUE_W-1:0] masked;
   logic [POS_W-1:0]   msb_pos;
   logic [10:0]        prod3;
   logic [8:0]         prod5;
   logic [3:0]         quot3;
   logic [2:0]         quot5;
   logic [POS_W-1:0]   offset3;
   logic [POS_W-1:0]   offset5;

   always_comb begin
      masked = req_bus.value & WORD_MASK;
      // priority encode the highest set bit; a zero word keeps position 0
      msb_pos = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (masked[i]) begin
            msb_pos = POS_W'(i);
         end
      end
      // divide by 3 and 5 through reciprocal multiplies, exact for 5-bit positions
      prod3   = {6'b0, msb_pos} * 11'd43;
      prod5   = {4'b0, msb_pos} * 9'd13;
      quot3   = prod3[10:7];
      quot5   = prod5[8:6];
      offset3 = {quot3, 1'b0} + {1'b0, quot3};
      offset5 = {quot5, 2'b00} + {2'b00, quot5};

      push_entry.value  = masked;
      push_entry.err    = 1'b0;
      push_entry.shift  = SHIFT_NONE;
      push_entry.offset = '0;
      case (req_bus.radix)
         RADIX_BIN: begin
            push_entry.shift  = SHIFT_BIN;
            push_entry.offset = msb_pos;
         end
         RADIX_QUAT: begin
            push_entry.shift  = SHIFT_QUAT;
            push_entry.offset = {msb_pos[POS_W-1:1], 1'b0};
         end
         RADIX_OCT: begin
            push_entry.shift  = SHIFT_OCT;
            push_entry.offset = offset3;
         end
         RADIX_HEX: begin
            push_entry.shift  = SHIFT_HEX;
            push_entry.offset = {msb_pos[POS_W-1:2], 2'b00};
         end
         RADIX_B32: begin
            push_entry.shift  = SHIFT_B32;
            push_entry.offset = offset5;
         end
         default: begin
            push_entry.err = 1'b1;
         end
      endcase

      push_valid    = req_bus.valid;
      req_bus.ready = push_ready;
   end

endmodule

### design/p2rd_queue.sv
// ---------------------------------------------------------------------------
// p2rd_queue: classified transaction queue
// Small register FIFO between the classifier and the digit engine.
// ---------------------------------------------------------------------------
module p2rd_queue #(
   parameter int DEPTH = p2rd_pkg::P2RD_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  p2rd_pkg::p2rd_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output p2rd_pkg::p2rd_entry_type pop_entry
);
   import p2rd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   p2rd_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   always_comb begin
      push_ready = (count_ff != CNT_W'(DEPTH));
      pop_valid  = (count_ff != '0);
      pop_entry  = slot_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/p2rd_back.sv
// ---------------------------------------------------------------------------
// p2rd_back: digit engine
// Walk the offset down one digit a cycle into the response register when free.
// ---------------------------------------------------------------------------
module p2rd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  p2rd_pkg::p2rd_entry_type pop_entry,
   p2rd_rsp_if.source               rsp_bus
);
   import p2rd_pkg::*;

   p2rd_entry_type    cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic              status_ff, status_in;
   logic              out_free, emit, done;
   logic [VALUE_W-1:0] shifted;
   logic [DIGIT_W-1:0] digit;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_bus.ready;
      emit      = busy_ff && out_free;
      done      = emit && (cur_ff.err || (cur_ff.offset == '0));
      pop_ready = !busy_ff || done;

      shifted = cur_ff.value >> cur_ff.offset;
      digit   = shifted[DIGIT_W-1:0] & digit_mask(cur_ff.shift);

      cur_in       = cur_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      status_in    = status_ff;

      // drop the delivered digit, then refill from the current transaction
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (cur_ff.err) begin
            char_in   = CHAR_ERROR;
            last_in   = 1'b1;
            status_in = STATUS_BAD_RADIX;
         end else begin
            char_in   = digit_to_ascii(digit);
            last_in   = (cur_ff.offset == '0);
            status_in = STATUS_OK;
         end
         cur_in.offset = cur_ff.offset - {{(POS_W-SHIFT_W){1'b0}}, cur_ff.shift};
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         cur_in  = pop_entry;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.digit_char = char_ff;
   assign rsp_bus.last       = last_ff;
   assign rsp_bus.status     = status_ff;

endmodule

### design/power_of_two_radix_digits.sv
// ---------------------------------------------------------------------------
// power_of_two_radix_digits: word to radix 2/4/8/16/32 ASCII digit emitter
// Path: queue slot, engine entry register, then the response register.
// Throughput: one digit per cycle while the response channel is ready.
// Reset: synchronous, active high; clears the queue, engine and response valid.
// ---------------------------------------------------------------------------
module power_of_two_radix_digits #(
   parameter int WORD_BITS   = p2rd_pkg::P2RD_WORD_BITS,
   parameter int QUEUE_DEPTH = p2rd_pkg::P2RD_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   p2rd_req_if.sink   req_bus,
   p2rd_rsp_if.source rsp_bus
);
   import p2rd_pkg::*;

   // Front to queue: one classified transaction per accepted request.
   logic           push_valid;
   logic           push_ready;
   p2rd_entry_type push_entry;

   // Queue to digit engine.
   logic           pop_valid;
   logic           pop_ready;
   p2rd_entry_type pop_entry;

   // Classify in the request cycle: mask the word to WORD_BITS, decode
   // the radix and find the bit offset of the top nonzero digit. The
   // request is taken whenever the queue has a free slot.
   p2rd_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .req_bus    (req_bus),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Hold classified transactions so the front keeps taking requests
   // while the engine spells out a long word.
   p2rd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Advance the offset by one digit each cycle the response register
   // frees; the next transaction loads on the cycle the last digit goes out.
   p2rd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_bus   (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   // An invalid radix produces a lone terminating zero character.
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == STATUS_BAD_RADIX) |->
         (rsp_bus.last && rsp_bus.digit_char == CHAR_ERROR))
      else $error("error response is not a single zero character");

   // A good response is always a digit of the radix 32 alphabet.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == STATUS_OK) |->
         ((rsp_bus.digit_char >= 7'h30 && rsp_bus.digit_char <= 7'h39) ||
          (rsp_bus.digit_char >= 7'h41 && rsp_bus.digit_char <= 7'h56)))
      else $error("digit character outside 0-9, A-V");

   // The response channel comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid after reset");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: power-of-two radix digit emitter
// Sends words with radix 2/4/8/16/32 (and bad radices) through the request
// channel, predicts the ASCII digit stream of each word and checks every
// response transaction in order. A directed table runs first, then random
// words under bursty request traffic and a response side that stalls.
// ---------------------------------------------------------------------------
module testbench;
   import p2rd_pkg::*;

   // How a directed row gets its expected digits: typed in by hand, worked
   // out by the digit predictor, or one error transaction for a bad radix.
   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_SPELLED,
      ROW_REJECTED
   } row_kind_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
      row_kind_type       kind;
      string              text;   // expected digits for ROW_SPELLED rows
   } stim_row_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
      logic              status;
   } digit_result_type;

   logic clock;
   logic reset;

   p2rd_req_if req_bus ();
   p2rd_rsp_if rsp_bus ();

   power_of_two_radix_digits dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Digits still owed by the block, oldest first.
   digit_result_type awaited_digits[$];
   stim_row_type     directed_rows[$];
   int               mismatch_count = 0;
   int               burst_left = 0;

   // -------------------------------------------------------------------------
   // Clock and run limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Worst case is far below this: about 210 words of up to 32 digits each,
   // every digit waiting out a response stall.
   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Digit predictor
   // -------------------------------------------------------------------------

   // Bits per digit for a supported radix; zero marks a radix to reject.
   function automatic int radix_bits(input logic [RADIX_W-1:0] radix);
      case (radix)
         RADIX_BIN:  return 1;
         RADIX_QUAT: return 2;
         RADIX_OCT:  return 3;
         RADIX_HEX:  return 4;
         RADIX_B32:  return 5;
         default:    return 0;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] ascii_of(input int d);
      if (d < 10) begin
         return CHAR_ZERO + CHAR_W'(d);
      end
      return CHAR_A + CHAR_W'(d - 10);
   endfunction

   // Queue the digits of one word, top digit first. The word is padded with
   // zeros at the top to a whole number of digits, so base 8 and base 32
   // see 33 and 35 bits. Leading zero digits are dropped, but one is kept.
   task automatic spell_expected_digits(input logic [VALUE_W-1:0] value,
                                        input logic [RADIX_W-1:0] radix);
      int                 bits;
      int                 digit_count;
      int                 top;
      int                 k;
      int                 d;
      logic [VALUE_W-1:0] chunk;
      digit_result_type   r;
      bits = radix_bits(radix);
      if (bits == 0) begin
         r.digit_char = CHAR_ERROR;
         r.last       = 1'b1;
         r.status     = STATUS_BAD_RADIX;
         awaited_digits.push_back(r);
         return;
      end
      digit_count = (P2RD_WORD_BITS + bits - 1) / bits;
      top = 0;
      for (k = 0; k < digit_count; k++) begin
         chunk = value >> (k * bits);
         if ((int'(chunk) & ((1 << bits) - 1)) != 0) begin
            top = k;
         end
      end
      for (k = top; k >= 0; k--) begin
         chunk        = value >> (k * bits);
         d            = int'(chunk) & ((1 << bits) - 1);
         r.digit_char = ascii_of(d);
         r.last       = (k == 0);
         r.status     = STATUS_OK;
         awaited_digits.push_back(r);
      end
   endtask

   // Queue a digit string typed in by hand.
   task automatic expect_spelled(input string text);
      digit_result_type r;
      for (int i = 0; i < text.len(); i++) begin
         r.digit_char = CHAR_W'(text[i]);
         r.last       = (i == text.len() - 1);
         r.status     = STATUS_OK;
         awaited_digits.push_back(r);
      end
   endtask

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Drive one word and hold it until the block takes it. Words go out in
   // bursts of random length; between bursts valid drops for a random gap,
   // and sometimes the next burst follows with no gap at all.
   task automatic send_word(input logic [VALUE_W-1:0] value,
                            input logic [RADIX_W-1:0] radix);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.value = value;
      req_bus.radix = radix;
      // Return at the edge that accepts the transaction.
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and hold off until every awaited digit has come back.
   task automatic wait_for_digits_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (awaited_digits.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Response side: ready follows its own pattern, switched at random between
   // always ready, coin flips, one cycle in four, and long stalls.
   // -------------------------------------------------------------------------
   initial begin
      int mode;
      int span;
      int tick;
      rsp_bus.ready = 1'b0;
      tick = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 80);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               0: rsp_bus.ready = 1'b1;
               1: rsp_bus.ready = 1'($urandom_range(0, 1));
               2: rsp_bus.ready = (tick % 4 == 0);
               default: rsp_bus.ready = ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Checker: compare each response transaction with the oldest awaited digit
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch in %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
      end
   endtask

   always @(posedge clock) begin : check_digits
      digit_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_digits.size() == 0) begin
            report_mismatch("digit with nothing awaited", 0, int'(rsp_bus.digit_char));
         end else begin
            want = awaited_digits.pop_front();
            if (rsp_bus.digit_char !== want.digit_char) begin
               report_mismatch("digit_char", int'(want.digit_char),
                               int'(rsp_bus.digit_char));
            end
            if (rsp_bus.last !== want.last) begin
               report_mismatch("last", int'(want.last), int'(rsp_bus.last));
            end
            if (rsp_bus.status !== want.status) begin
               report_mismatch("status", int'(want.status), int'(rsp_bus.status));
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      stim_row_type       row;
      logic [VALUE_W-1:0] word;
      logic [RADIX_W-1:0] radix;

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      req_bus.radix = '0;

      // Zero word in every radix, straight after reset: one '0' each.
      directed_rows.push_back('{32'h0000_0000, RADIX_BIN,  ROW_SPELLED, "0"});
      directed_rows.push_back('{32'h0000_0000, RADIX_QUAT, ROW_SPELLED, "0"});
      directed_rows.push_back('{32'h0000_0000, RADIX_OCT,  ROW_SPELLED, "0"});
      directed_rows.push_back('{32'h0000_0000, RADIX_HEX,  ROW_SPELLED, "0"});
      directed_rows.push_back('{32'h0000_0000, RADIX_B32,  ROW_SPELLED, "0"});
      // All ones: the longest strings, and the zero-padded top digit in
      // base 8 and base 32.
      directed_rows.push_back('{32'hFFFF_FFFF, RADIX_BIN,  ROW_SPELLED,
                                "11111111111111111111111111111111"});
      directed_rows.push_back('{32'hFFFF_FFFF, RADIX_QUAT, ROW_SPELLED, "3333333333333333"});
      directed_rows.push_back('{32'hFFFF_FFFF, RADIX_OCT,  ROW_SPELLED, "37777777777"});
      directed_rows.push_back('{32'hFFFF_FFFF, RADIX_HEX,  ROW_SPELLED, "FFFFFFFF"});
      directed_rows.push_back('{32'hFFFF_FFFF, RADIX_B32,  ROW_SPELLED, "3VVVVVV"});
      // Short words and the edges of the digit alphabet.
      directed_rows.push_back('{32'h0000_0001, RADIX_BIN,  ROW_SPELLED, "1"});
      directed_rows.push_back('{32'h0000_009A, RADIX_HEX,  ROW_SPELLED, "9A"});
      directed_rows.push_back('{32'h0000_000A, RADIX_B32,  ROW_SPELLED, "A"});
      directed_rows.push_back('{32'h0000_001F, RADIX_B32,  ROW_SPELLED, "V"});
      // Leading zero suppression and top bits alone.
      directed_rows.push_back('{32'h0123_ABCD, RADIX_HEX,  ROW_PREDICTED, ""});
      directed_rows.push_back('{32'h8000_0000, RADIX_BIN,  ROW_PREDICTED, ""});
      directed_rows.push_back('{32'h8000_0000, RADIX_OCT,  ROW_PREDICTED, ""});
      directed_rows.push_back('{32'h4000_0000, RADIX_B32,  ROW_PREDICTED, ""});
      directed_rows.push_back('{32'hDEAD_BEEF, RADIX_QUAT, ROW_PREDICTED, ""});
      // Unsupported radices: one error transaction each, whatever the word.
      directed_rows.push_back('{32'h1234_5678, 6'd0,  ROW_REJECTED, ""});
      directed_rows.push_back('{32'hFFFF_FFFF, 6'd1,  ROW_REJECTED, ""});
      directed_rows.push_back('{32'h0000_0000, 6'd3,  ROW_REJECTED, ""});
      directed_rows.push_back('{32'hFFFF_FFFF, 6'd31, ROW_REJECTED, ""});
      directed_rows.push_back('{32'hAAAA_AAAA, 6'd24, ROW_REJECTED, ""});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_word(row.value, row.radix);
         case (row.kind)
            ROW_SPELLED: begin
               expect_spelled(row.text);
            end
            ROW_REJECTED: begin
               awaited_digits.push_back('{CHAR_ERROR, 1'b1, STATUS_BAD_RADIX});
            end
            default: begin
               spell_expected_digits(row.value, row.radix);
            end
         endcase
      end
      wait_for_digits_drained();

      // Random words: mostly valid radices, with word shapes that give
      // every string length from one digit to a full word.
      for (int n = 0; n < 190; n++) begin
         if (n == 95) begin
            wait_for_digits_drained();
         end
         case ($urandom_range(0, 4))
            0: word = $urandom;
            1: word = $urandom >> $urandom_range(1, 31);
            2: word = $urandom_range(0, 40);
            3: word = 32'h1 << $urandom_range(0, 31);
            default: word = 32'hFFFF_FFFF >> $urandom_range(0, 31);
         endcase
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0: radix = RADIX_BIN;
               1: radix = RADIX_QUAT;
               2: radix = RADIX_OCT;
               3: radix = RADIX_HEX;
               default: radix = RADIX_B32;
            endcase
         end else begin
            radix = RADIX_W'($urandom_range(0, 32));
         end
         send_word(word, radix);
         spell_expected_digits(word, radix);
      end
      wait_for_digits_drained();

      // Give any stray digit time to show up before the verdict.
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

### filelist.f
design/p2rd_pkg.sv
design/p2rd_if.sv
design/p2rd_front.sv
design/p2rd_queue.sv
design/p2rd_back.sv
design/power_of_two_radix_digits.sv
tb/testbench.sv
